>>> design/jsr_pkg.sv
// Package for the Jaumann stress rotation block: pipeline constants, types
// and the arithmetic helpers that the datapath stages share.
// No dependencies.
`timescale 1ns / 1ps

package jsr_pkg;

  localparam int NUM_STAGES = 18;
  localparam int LAST = NUM_STAGES - 1;

  // Stage numbers of the pipeline.
  localparam int ST_FULL = 0;
  localparam int ST_PROD = 1;
  localparam int ST_ROT = 2;
  localparam int ST_SUM = 3;
  localparam int ST_DIVA = 4;
  localparam int ST_DIVB = 5;
  localparam int ST_SAT = 6;
  localparam int ST_SQ = 7;
  localparam int ST_ACC = 8;
  localparam int ST_T = 9;
  localparam int ST_ROOT0 = 10;
  localparam int SQRT_STEPS = 4;

  // Division by three: floor(x/3) = (x*M) >> K for x < 2^(K-1), M = (2^K+1)/3.
  localparam logic [21:0] DIV3_M22 = 22'd2796203;
  localparam logic [23:0] DIV3_M24 = 24'd11184811;
  localparam logic signed [43:0] SUM_BIAS = 44'sd6597069766656;  // 3*2^41
  localparam logic signed [44:0] QUO_BIAS = 45'sd2199023255552;  // 2^41

  localparam logic [30:0] VM_MAX = 31'h7fffffff;

  typedef logic [6:0][31:0] stress_t;  // [0] mean, [1..6] deviator

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sqrt_t;

  function automatic logic signed [65:0] smul(input logic signed [33:0] a,
                                              input logic signed [31:0] b);
    logic signed [65:0] ae;
    logic signed [65:0] be;
    ae = a;
    be = b;
    return ae * be;
  endfunction

  function automatic logic signed [39:0] floor_shr(input logic signed [65:0] p,
                                                   input int unsigned n);
    logic signed [65:0] s;
    s = p >>> n;
    return s[39:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [42:0] v);
    if (v > 43'sd2147483647) begin
      return 32'h7fffffff;
    end else if (v < -43'sd2147483648) begin
      return 32'h80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // One digit of the restoring square root: brings down two radicand bits.
  function automatic sqrt_t sqrt_step(input sqrt_t s);
    logic [35:0] r;
    logic [35:0] trial;
    sqrt_t o;
    r = {s.rem, s.rad[63:62]};
    trial = {2'b00, s.root, 2'b01};
    if (r >= trial) begin
      o.rem = 34'(r - trial);
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem = r[33:0];
      o.root = {s.root[30:0], 1'b0};
    end
    o.rad = {s.rad[61:0], 2'b00};
    return o;
  endfunction

endpackage

>>> design/jaumann_stress_rotation.sv
// Top level of the Jaumann stress rotation with von Mises equivalent stress.
// Depends on jsr_pkg.
//
//   channel | handshake              | payload
//   input   | in_valid / in_ready    | mean_in, dev_*_in, shear_*_in, spin_x/y/z
//   output  | out_valid / out_ready  | mean_out, dev_*_out, shear_*_out, von_mises
//
// An 18-stage pipeline takes one beat per cycle unless it is full and the output
// stalls; a beat leaves the last stage while out_ready is high. The length
// is set by the rotation products, the two-step division by three, the squares
// and the square root, which settles four result bits per stage. Each stage
// moves when it is empty or its successor moves, so bubbles close up under a
// stall and nothing is dropped.
// Reset clears only the stage valid bits.
`timescale 1ns / 1ps

module jaumann_stress_rotation import jsr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] mean_in,
  input  logic signed [31:0] dev_xx_in,
  input  logic signed [31:0] dev_yy_in,
  input  logic signed [31:0] dev_zz_in,
  input  logic signed [31:0] shear_yz_in,
  input  logic signed [31:0] shear_zx_in,
  input  logic signed [31:0] shear_xy_in,
  input  logic signed [31:0] spin_x,
  input  logic signed [31:0] spin_y,
  input  logic signed [31:0] spin_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] mean_out,
  output logic signed [31:0] dev_xx_out,
  output logic signed [31:0] dev_yy_out,
  output logic signed [31:0] dev_zz_out,
  output logic signed [31:0] shear_yz_out,
  output logic signed [31:0] shear_zx_out,
  output logic signed [31:0] shear_xy_out,
  output logic        [30:0] von_mises
);

  logic [LAST:0] vld;
  logic [LAST:0] adv;

  // Stage 0: full stress, normal differences, spins.
  logic signed [32:0] sfull [3];
  logic signed [33:0] sdiff [3];   // xx-yy, yy-zz, zz-xx
  logic signed [31:0] sshr  [3];   // yz, zx, xy
  logic signed [31:0] spin  [3];
  // Stage 1: products.
  logic signed [65:0] prod  [12];
  logic signed [32:0] sfull1 [3];
  logic signed [31:0] sshr1  [3];
  // Stages 2..5: rotated full stress.
  logic signed [39:0] nstr [ST_ROT:ST_DIVB][6];
  logic [43:0] usum;
  logic [20:0] qhi;
  logic [1:0]  rhi;
  logic [21:0] ulo;
  logic signed [41:0] mn;
  // Stages 6..17: saturated stress outputs.
  stress_t str [ST_SAT:LAST];
  logic [62:0] sq [6];
  logic [63:0] sn;
  logic [63:0] ss;
  logic [ST_T:LAST] ovf;
  sqrt_t sqs [ST_T:LAST];

  // A stage can move when it or any stage after it is empty, or the output drains.
  always_comb begin
    logic room;
    room = out_ready;
    for (int k = LAST; k >= 0; k--) begin
      room = room || !vld[k];
      adv[k] = room;
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_FULL]) begin
      sfull[0] <= 33'(dev_xx_in) + 33'(mean_in);
      sfull[1] <= 33'(dev_yy_in) + 33'(mean_in);
      sfull[2] <= 33'(dev_zz_in) + 33'(mean_in);
      sdiff[0] <= 34'(dev_xx_in) - 34'(dev_yy_in);
      sdiff[1] <= 34'(dev_yy_in) - 34'(dev_zz_in);
      sdiff[2] <= 34'(dev_zz_in) - 34'(dev_xx_in);
      sshr[0] <= shear_yz_in;
      sshr[1] <= shear_zx_in;
      sshr[2] <= shear_xy_in;
      spin[0] <= spin_x;
      spin[1] <= spin_y;
      spin[2] <= spin_z;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_PROD]) begin
      prod[0]  <= smul(34'(sshr[2]), spin[2]);
      prod[1]  <= smul(34'(sshr[1]), spin[1]);
      prod[2]  <= smul(34'(sshr[0]), spin[0]);
      prod[3]  <= smul(sdiff[1], spin[0]);
      prod[4]  <= smul(34'(sshr[1]), spin[2]);
      prod[5]  <= smul(34'(sshr[2]), spin[1]);
      prod[6]  <= smul(sdiff[2], spin[1]);
      prod[7]  <= smul(34'(sshr[2]), spin[0]);
      prod[8]  <= smul(34'(sshr[0]), spin[2]);
      prod[9]  <= smul(sdiff[0], spin[2]);
      prod[10] <= smul(34'(sshr[0]), spin[1]);
      prod[11] <= smul(34'(sshr[1]), spin[0]);
      sfull1 <= sfull;
      sshr1 <= sshr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_ROT]) begin
      nstr[ST_ROT][0] <= 40'(sfull1[0]) - floor_shr(prod[0], 29) + floor_shr(prod[1], 29);
      nstr[ST_ROT][1] <= 40'(sfull1[1]) + floor_shr(prod[0], 29) - floor_shr(prod[2], 29);
      nstr[ST_ROT][2] <= 40'(sfull1[2]) - floor_shr(prod[1], 29) + floor_shr(prod[2], 29);
      nstr[ST_ROT][3] <= 40'(sshr1[0]) + floor_shr(prod[3], 30) + floor_shr(prod[4], 30)
                         - floor_shr(prod[5], 30);
      nstr[ST_ROT][4] <= 40'(sshr1[1]) + floor_shr(prod[6], 30) + floor_shr(prod[7], 30)
                         - floor_shr(prod[8], 30);
      nstr[ST_ROT][5] <= 40'(sshr1[2]) + floor_shr(prod[9], 30) + floor_shr(prod[10], 30)
                         - floor_shr(prod[11], 30);
    end
  end

  // The trace is biased by a multiple of three so the division works on a
  // nonnegative value; it is split into two 22-bit digits.
  logic signed [41:0] tr;
  logic signed [43:0] trb;
  always_comb begin
    tr = 42'(nstr[ST_ROT][0]) + 42'(nstr[ST_ROT][1]) + 42'(nstr[ST_ROT][2]);
    trb = 44'(tr) + SUM_BIAS;
  end

  always_ff @(posedge clk) begin
    if (adv[ST_SUM]) begin
      usum <= trb;
      nstr[ST_SUM] <= nstr[ST_ROT];
    end
  end

  logic [43:0] pa;
  logic [20:0] qa;
  logic [21:0] ra;
  always_comb begin
    pa = 44'(usum[43:22]) * 44'(DIV3_M22);
    qa = pa[43:23];
    ra = usum[43:22] - 22'(qa) * 22'd3;
  end

  always_ff @(posedge clk) begin
    if (adv[ST_DIVA]) begin
      qhi <= qa;
      rhi <= ra[1:0];
      ulo <= usum[21:0];
      nstr[ST_DIVA] <= nstr[ST_SUM];
    end
  end

  logic [47:0] pb;
  logic [44:0] quo;
  logic signed [44:0] mnw;
  always_comb begin
    pb = 48'({rhi, ulo}) * 48'(DIV3_M24);
    quo = {2'b00, qhi, 22'd0} + {22'd0, pb[47:25]};
    mnw = $signed(quo) - QUO_BIAS;
  end

  always_ff @(posedge clk) begin
    if (adv[ST_DIVB]) begin
      mn <= mnw[41:0];
      nstr[ST_DIVB] <= nstr[ST_DIVA];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_SAT]) begin
      str[ST_SAT][0] <= sat32(43'(mn));
      str[ST_SAT][1] <= sat32(43'(nstr[ST_DIVB][0]) - 43'(mn));
      str[ST_SAT][2] <= sat32(43'(nstr[ST_DIVB][1]) - 43'(mn));
      str[ST_SAT][3] <= sat32(43'(nstr[ST_DIVB][2]) - 43'(mn));
      str[ST_SAT][4] <= sat32(43'(nstr[ST_DIVB][3]));
      str[ST_SAT][5] <= sat32(43'(nstr[ST_DIVB][4]));
      str[ST_SAT][6] <= sat32(43'(nstr[ST_DIVB][5]));
    end
    for (int k = ST_SQ; k <= LAST; k++) begin
      if (adv[k]) begin
        str[k] <= str[k-1];
      end
    end
  end

  logic signed [63:0] sqw [6];
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      sqw[i] = 64'($signed(str[ST_SAT][i+1])) * 64'($signed(str[ST_SAT][i+1]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_SQ]) begin
      for (int i = 0; i < 6; i++) begin
        sq[i] <= sqw[i][62:0];
      end
    end
    if (adv[ST_ACC]) begin
      sn <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
      ss <= 64'(sq[3]) + 64'(sq[4]) + 64'(sq[5]);
    end
  end

  // 3*J2 at 2^-32 scale: 1.5 times the normal squares plus 3 times the shears.
  logic [65:0] tj;
  sqrt_t sq_init;
  always_comb begin
    tj = {2'b00, sn} + {3'b000, sn[63:1]} + {2'b00, ss} + {1'b0, ss, 1'b0};
    sq_init.rem = '0;
    sq_init.root = '0;
    sq_init.rad = {2'b00, tj[61:0]};
  end

  sqrt_t sq_next [ST_ROOT0:LAST];
  always_comb begin
    for (int k = ST_ROOT0; k <= LAST; k++) begin
      sq_next[k] = sqs[k-1];
      for (int j = 0; j < SQRT_STEPS; j++) begin
        sq_next[k] = sqrt_step(sq_next[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_T]) begin
      ovf[ST_T] <= (|sn[63:62]) || (|ss[63:61]) || (|tj[65:62]);
      sqs[ST_T] <= sq_init;
    end
    for (int k = ST_ROOT0; k <= LAST; k++) begin
      if (adv[k]) begin
        sqs[k] <= sq_next[k];
        ovf[k] <= ovf[k-1];
      end
    end
  end

  assign out_valid    = vld[LAST];
  assign mean_out     = str[LAST][0];
  assign dev_xx_out   = str[LAST][1];
  assign dev_yy_out   = str[LAST][2];
  assign dev_zz_out   = str[LAST][3];
  assign shear_yz_out = str[LAST][4];
  assign shear_zx_out = str[LAST][5];
  assign shear_xy_out = str[LAST][6];
  assign von_mises    = ovf[LAST] ? VM_MAX : sqs[LAST].root[30:0];

endmodule

>>> design/jsr_checker.sv
// Port-level checks for the Jaumann stress rotation block, bound to its top.
// Depends on jaumann_stress_rotation.
`timescale 1ns / 1ps

module jsr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] dev_xx_out,
  input logic [31:0] dev_yy_out,
  input logic [31:0] dev_zz_out,
  input logic [31:0] shear_yz_out,
  input logic [31:0] shear_zx_out,
  input logic [31:0] shear_xy_out,
  input logic [30:0] von_mises
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(von_mises) && $stable(dev_xx_out))
    else $error("output beat changed while stalled");

  // The input side only stalls when the pipeline is full and the output waits.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  a_zero_dev: assert property (@(posedge clk) disable iff (rst)
    out_valid && dev_xx_out == 32'd0 && dev_yy_out == 32'd0 && dev_zz_out == 32'd0
    && shear_yz_out == 32'd0 && shear_zx_out == 32'd0 && shear_xy_out == 32'd0
    |-> von_mises == 31'd0)
    else $error("nonzero equivalent stress for a zero deviator");

endmodule

bind jaumann_stress_rotation jsr_checker u_jsr_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .dev_xx_out(dev_xx_out),
  .dev_yy_out(dev_yy_out),
  .dev_zz_out(dev_zz_out),
  .shear_yz_out(shear_yz_out),
  .shear_zx_out(shear_zx_out),
  .shear_xy_out(shear_xy_out),
  .von_mises(von_mises)
);
